@@ design/sle_pkg.sv @@
package sle_pkg;

    localparam int SCAN_W       = 8;
    localparam int KEY_W        = 7;
    localparam int CHAR_W       = 7;
    localparam int KIND_W       = 2;
    localparam int FILL_W       = 6;
    localparam int LINE_LEN_DEF = 32;
    localparam int MAP_DEPTH    = 58;

    localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
    localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
    localparam logic [KEY_W-1:0] KEY_BKSP   = 7'h0E;

    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
    localparam logic [CHAR_W-1:0] CH_NL    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

    localparam logic [CHAR_W-1:0] PLAIN_MAP [MAP_DEPTH] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h00, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
        7'h00, 7'h20
    };

    localparam logic [CHAR_W-1:0] SHIFT_MAP [MAP_DEPTH] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h00, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
        7'h00, 7'h20
    };

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_BS,
        SEL_BS_LAST,
        SEL_SPACE,
        SEL_CHAR,
        SEL_NL,
        SEL_LINE,
        SEL_END
    } emit_sel_t;

    typedef struct packed {
        logic      capture;
        logic      decode;
        logic      write_char;
        logic      bksp;
        logic      clear_ptr;
        logic      line_adv;
        logic      clear_fill;
        emit_sel_t emit_sel;
    } sle_cmd_t;

    typedef struct packed {
        logic released;
        logic is_bksp;
        logic ch_zero;
        logic ch_nl;
        logic fill_zero;
        logic line_full;
        logic line_done;
        logic out_free;
    } sle_sts_t;

    function automatic logic [CHAR_W-1:0] key_to_ascii(input logic [KEY_W-1:0] key,
                                                       input logic shift);
        logic [CHAR_W-1:0] ch;
        ch = CH_NUL;
        if (key < KEY_W'(MAP_DEPTH))
        begin
            ch = shift ? SHIFT_MAP[key[5:0]] : PLAIN_MAP[key[5:0]];
        end
        return ch;
    endfunction

endpackage

@@ design/sle_if.sv @@
interface sle_key_if
    import sle_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SCAN_W-1:0] scancode;
    logic              released;

    modport source (output valid, output scancode, output released, input ready);
    modport sink   (input valid, input scancode, input released, output ready);
endinterface

interface sle_res_if
    import sle_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] char_value;
    logic              last;

    modport source (output valid, output kind, output char_value, output last, input ready);
    modport sink   (input valid, input kind, input char_value, input last, output ready);
endinterface

@@ design/sle_ram.sv @@
module sle_ram
    import sle_pkg::*;
#(
    parameter int WIDTH = CHAR_W,
    parameter int DEPTH = LINE_LEN_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/sle_datapath.sv @@
module sle_datapath
    import sle_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sle_cmd_t          cmd,
    output sle_sts_t          sts,
    input  logic [SCAN_W-1:0] scancode,
    input  logic              released,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] out_kind,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;

    logic [KEY_W-1:0]  key_reg;
    logic              rel_reg;
    logic              shift_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] ptr_reg;
    logic [FILL_W-1:0] ptr_next;
    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;

    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] rdata;

    assign ch = key_to_ascii(key_reg, shift_reg);

    always_comb
    begin
        sts.released  = rel_reg;
        sts.is_bksp   = (key_reg == KEY_BKSP);
        sts.ch_zero   = (ch == CH_NUL);
        sts.ch_nl     = (ch == CH_NL);
        sts.fill_zero = (fill_reg == '0);
        sts.line_full = (fill_reg >= FILL_W'(LINE_LEN));
        sts.line_done = (ptr_reg == fill_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // read address runs one step ahead so that rdata always shows line[ptr]
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.clear_ptr)
        begin
            ptr_next = '0;
        end
        else if (cmd.line_adv)
        begin
            ptr_next = ptr_reg + FILL_W'(1);
        end
    end

    sle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_LEN)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.write_char),
        .waddr (fill_reg[AW-1:0]),
        .wdata (ch),
        .raddr (ptr_next[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= scancode[KEY_W-1:0];
            rel_reg <= released;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            fill_reg  <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.decode && (key_reg == KEY_LSHIFT || key_reg == KEY_RSHIFT))
            begin
                shift_reg <= !rel_reg;
            end
            if (cmd.clear_fill)
            begin
                fill_reg <= '0;
            end
            else if (cmd.write_char)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (cmd.bksp)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sel != SEL_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.emit_sel)
            SEL_BS:
            begin
                out_kind_reg <= KIND_ECHO;
                out_char_reg <= CH_BS;
                out_last_reg <= 1'b0;
            end
            SEL_BS_LAST:
            begin
                out_kind_reg <= KIND_ECHO;
                out_char_reg <= CH_BS;
                out_last_reg <= 1'b1;
            end
            SEL_SPACE:
            begin
                out_kind_reg <= KIND_ECHO;
                out_char_reg <= CH_SPACE;
                out_last_reg <= 1'b0;
            end
            SEL_CHAR:
            begin
                out_kind_reg <= KIND_ECHO;
                out_char_reg <= ch;
                out_last_reg <= 1'b1;
            end
            SEL_NL:
            begin
                out_kind_reg <= KIND_ECHO;
                out_char_reg <= CH_NL;
                out_last_reg <= 1'b0;
            end
            SEL_LINE:
            begin
                out_kind_reg <= KIND_LINE;
                out_char_reg <= rdata;
                out_last_reg <= 1'b0;
            end
            SEL_END:
            begin
                out_kind_reg <= KIND_END;
                out_char_reg <= CH_NUL;
                out_last_reg <= 1'b1;
            end
            default:
            begin
                out_kind_reg <= out_kind_reg;
                out_char_reg <= out_char_reg;
                out_last_reg <= out_last_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

@@ design/sle_ctrl.sv @@
module sle_ctrl
    import sle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sle_sts_t sts,
    output sle_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BS1,
        ST_SPACE,
        ST_BS2,
        ST_CHAR,
        ST_NL,
        ST_LINE,
        ST_ENDM
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit_sel = SEL_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.released)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.is_bksp)
                begin
                    // backspace on an empty line is dropped
                    if (sts.fill_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.bksp   = 1'b1;
                        state_next = ST_BS1;
                    end
                end
                else if (sts.ch_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.ch_nl)
                begin
                    cmd.clear_ptr = 1'b1;
                    state_next    = ST_NL;
                end
                else if (sts.line_full)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.write_char = 1'b1;
                    state_next     = ST_CHAR;
                end
            end
            ST_BS1:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel = SEL_BS;
                    state_next   = ST_SPACE;
                end
            end
            ST_SPACE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel = SEL_SPACE;
                    state_next   = ST_BS2;
                end
            end
            ST_BS2:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel = SEL_BS_LAST;
                    state_next   = ST_IDLE;
                end
            end
            ST_CHAR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel = SEL_CHAR;
                    state_next   = ST_IDLE;
                end
            end
            ST_NL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel = SEL_NL;
                    state_next   = ST_LINE;
                end
            end
            ST_LINE:
            begin
                if (sts.line_done)
                begin
                    state_next = ST_ENDM;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_sel = SEL_LINE;
                    cmd.line_adv = 1'b1;
                end
            end
            ST_ENDM:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sel   = SEL_END;
                    cmd.clear_fill = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

@@ design/scancode_line_editor_top.sv @@
// Line editor for set-1 keyboard events.
// keys: one transaction per key event (scancode, released). Shift keys track
//   the shift state; other releases and unmapped keys give nothing.
// results: echo characters, the stored line on Enter, and an end marker;
//   last marks the final transaction caused by a key event.
// A stored character is echoed from the output register after the decode and
//   char states. Backspace gives three echoes, one per cycle while the receiver
//   takes them. Enter gives the newline echo, then the line one character per
//   cycle while the receiver takes them, then the end marker.
// One key event is taken at a time; the next is accepted once the controller
//   is back in idle. The line RAM read port sets the rate of the line dump.
// A stalled receiver holds the output register; the controller waits and no
//   result is lost. The next key event is taken while the last result of the
//   previous one still waits in the output register.
// Reset clears the shift state, the line fill and the output valid flag.
module scancode_line_editor_top
    import sle_pkg::*;
#(
    parameter int LINE_LEN = LINE_LEN_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    sle_key_if.sink   keys,
    sle_res_if.source results
);

    sle_cmd_t cmd;
    sle_sts_t sts;

    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (keys.valid),
        .in_ready (keys.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sle_datapath #(
        .LINE_LEN (LINE_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .scancode  (keys.scancode),
        .released  (keys.released),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_kind  (results.kind),
        .out_char  (results.char_value),
        .out_last  (results.last)
    );

endmodule

@@ bench/scancode_line_editor_top_tb.sv @@
module scancode_line_editor_top_tb;
    import sle_pkg::*;

    localparam int LINE_LEN       = LINE_LEN_DEF;
    localparam int KEY_BUDGET     = 250;
    localparam int QUIET_TAIL     = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // set-1 keycodes used by the directed tests
    localparam logic [KEY_W-1:0] KEY_NONE  = 7'h00;
    localparam logic [KEY_W-1:0] KEY_1     = 7'h02;
    localparam logic [KEY_W-1:0] KEY_EQUAL = 7'h0D;
    localparam logic [KEY_W-1:0] KEY_TAB   = 7'h0F;
    localparam logic [KEY_W-1:0] KEY_ENTER = 7'h1C;
    localparam logic [KEY_W-1:0] KEY_CTRL  = 7'h1D;
    localparam logic [KEY_W-1:0] KEY_A     = 7'h1E;
    localparam logic [KEY_W-1:0] KEY_Z     = 7'h2C;
    localparam logic [KEY_W-1:0] KEY_SPACE = 7'h39;
    localparam logic [KEY_W-1:0] KEY_CAPS  = 7'h3A;
    localparam logic [KEY_W-1:0] KEY_TOP   = 7'h7F;

    localparam logic PRESS   = 1'b0;
    localparam logic RELEASE = 1'b1;

    // ASCII tables, keycodes 0x00..0x39; everything above is unmapped
    localparam logic [CHAR_W-1:0] UNSHIFTED [MAP_DEPTH] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h00, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
        7'h00, 7'h20
    };

    localparam logic [CHAR_W-1:0] SHIFTED [MAP_DEPTH] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h00, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
        7'h00, 7'h20
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_value;
        logic              last;
    } screen_char_t;

    logic clk = 1'b0;
    logic rst_n;

    sle_key_if key_bus ();
    sle_res_if res_bus ();

    scancode_line_editor_top #(.LINE_LEN(LINE_LEN)) uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .keys    (key_bus),
        .results (res_bus)
    );

    always #6 clk = ~clk;

    // editor state as the testbench sees it
    logic              shift_down;
    logic [CHAR_W-1:0] line_copy [LINE_LEN];
    int                line_len_now;

    screen_char_t      screen_q [$];
    screen_char_t      want;
    int                faults = 0;
    int                keys_sent;
    int                stall_left = 0;
    logic              quiet_tail;

    function automatic void push_char(input logic [KIND_W-1:0] kind,
                                      input logic [CHAR_W-1:0] ch,
                                      input logic last);
        screen_char_t c;
        c.kind       = kind;
        c.char_value = ch;
        c.last       = last;
        screen_q.push_back(c);
    endfunction

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [KEY_W-1:0] key,
                                                   input logic shifted);
        logic [CHAR_W-1:0] ch;
        ch = CH_NUL;
        if (int'(key) < MAP_DEPTH)
            ch = shifted ? SHIFTED[key[5:0]] : UNSHIFTED[key[5:0]];
        return ch;
    endfunction

    // Apply one key event to the local line copy and queue what should appear
    function automatic void edit_line(input logic [SCAN_W-1:0] sc, input logic rel);
        logic [KEY_W-1:0]  key;
        logic [CHAR_W-1:0] ch;
        int                i;
        key = sc[KEY_W-1:0];
        if (key == KEY_LSHIFT || key == KEY_RSHIFT)
            shift_down = !rel;
        if (rel)
            return;
        if (key == KEY_BKSP)
        begin
            if (line_len_now == 0)
                return;
            line_len_now--;
            push_char(KIND_ECHO, CH_BS, 1'b0);
            push_char(KIND_ECHO, CH_SPACE, 1'b0);
            push_char(KIND_ECHO, CH_BS, 1'b1);
            return;
        end
        ch = ascii_of(key, shift_down);
        if (ch == CH_NUL)
            return;
        if (ch == CH_NL)
        begin
            push_char(KIND_ECHO, CH_NL, 1'b0);
            for (i = 0; i < line_len_now; i++)
                push_char(KIND_LINE, line_copy[i], 1'b0);
            push_char(KIND_END, CH_NUL, 1'b1);
            line_len_now = 0;
            return;
        end
        if (line_len_now >= LINE_LEN)
            return;
        line_copy[line_len_now] = ch;
        line_len_now++;
        push_char(KIND_ECHO, ch, 1'b1);
    endfunction

    // Present one key event, hold it until taken, then predict its effect
    task automatic send_key(input logic [SCAN_W-1:0] sc, input logic rel);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            key_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_bus.valid    <= 1'b1;
        key_bus.scancode <= sc;
        key_bus.released <= rel;
        do @(posedge clk); while (!key_bus.ready);
        edit_line(sc, rel);
        keys_sent++;
    endtask

    task automatic press(input logic [KEY_W-1:0] key, input logic hi_bit);
        send_key({hi_bit, key}, PRESS);
    endtask

    task automatic release_key(input logic [KEY_W-1:0] key, input logic hi_bit);
        send_key({hi_bit, key}, RELEASE);
    endtask

    function automatic logic [KEY_W-1:0] pick_char_key();
        logic [KEY_W-1:0] k;
        do
            k = KEY_W'($urandom_range(2, MAP_DEPTH - 1));
        while (UNSHIFTED[k[5:0]] == CH_NUL || k == KEY_BKSP || k == KEY_ENTER);
        return k;
    endfunction

    task automatic test_silent_keys();
        press(KEY_NONE, 1'b0);
        press(KEY_CTRL, 1'b0);
        press(KEY_CAPS, 1'b0);
        press(KEY_TOP, 1'b1);           // scancode 0xFF
        release_key(KEY_A, 1'b1);
        press(KEY_BKSP, 1'b0);          // backspace with nothing stored
    endtask

    task automatic test_typing();
        press(KEY_A, 1'b0);
        press(KEY_1, 1'b1);             // bit 7 set on a press still maps
        press(KEY_LSHIFT, 1'b0);        // shift on its own echoes nothing
        press(KEY_A, 1'b0);
        press(KEY_EQUAL, 1'b0);
        release_key(KEY_RSHIFT, 1'b1);  // either shift release drops shift
        press(KEY_SPACE, 1'b0);
        press(KEY_TAB, 1'b0);
    endtask

    task automatic test_backspace();
        press(KEY_BKSP, 1'b1);
        release_key(KEY_BKSP, 1'b1);
    endtask

    task automatic test_enter();
        press(KEY_ENTER, 1'b0);
        press(KEY_ENTER, 1'b1);         // empty line: newline then end marker
        release_key(KEY_ENTER, 1'b1);
    endtask

    task automatic test_shift_keys();
        press(KEY_RSHIFT, 1'b0);
        press(KEY_Z, 1'b0);
        release_key(KEY_LSHIFT, 1'b0);  // release flag set, bit 7 clear
        press(KEY_Z, 1'b0);
        press(KEY_ENTER, 1'b0);
    endtask

    // One line of random editing, closed by Enter. A dense line is plain typing.
    task automatic type_random_line(input int len, input bit dense);
        int               r;
        int               k;
        logic [KEY_W-1:0] key;
        for (k = 0; k < len; k++)
        begin
            r = dense ? 19 : $urandom_range(0, 19);
            if (r == 0)
                send_key(SCAN_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (r <= 2)
                press(KEY_BKSP, 1'($urandom_range(0, 1)));
            else if (r == 3)
            begin
                key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
                if (shift_down)
                    release_key(key, 1'($urandom_range(0, 1)));
                else
                    press(key, 1'($urandom_range(0, 1)));
            end
            else
            begin
                key = pick_char_key();
                press(key, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 2) == 0)
                    release_key(key, 1'b1);
            end
        end
        press(KEY_ENTER, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_line_overflow();
        type_random_line(LINE_LEN + 4, 1'b1);
    endtask

    task automatic test_random_lines();
        int len;
        while (keys_sent < KEY_BUDGET)
        begin
            if (keys_sent >= KEY_BUDGET - QUIET_TAIL)
                quiet_tail = 1'b1;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 40)
                                               : $urandom_range(0, 12);
            type_random_line(len, 1'b0);
        end
    endtask

    // result checking and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (screen_q.size() == 0)
            begin
                $error("unexpected transaction: kind %0d char_value %0d last %0d",
                       res_bus.kind, res_bus.char_value, res_bus.last);
                faults++;
            end
            else
            begin
                want = screen_q.pop_front();
                if (res_bus.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, res_bus.kind);
                    faults++;
                end
                if (res_bus.char_value !== want.char_value)
                begin
                    $error("char_value: expected %0d, got %0d",
                           want.char_value, res_bus.char_value);
                    faults++;
                end
                if (res_bus.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, res_bus.last);
                    faults++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res_bus.ready <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            res_bus.ready <= 1'b0;
        end
        else
            res_bus.ready <= 1'b1;
    end

    // ends the run if no transaction moves on either side for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (key_bus.valid && key_bus.ready)
                       || (res_bus.valid && res_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[scancode_line_editor_top] ERROR");
        $finish;
    end

    initial
    begin
        shift_down       = 1'b0;
        line_len_now     = 0;
        keys_sent        = 0;
        quiet_tail       = 1'b0;
        rst_n            <= 1'b0;
        key_bus.valid    <= 1'b0;
        key_bus.scancode <= '0;
        key_bus.released <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_silent_keys();
        test_typing();
        test_backspace();
        test_enter();
        test_shift_keys();
        test_line_overflow();
        test_random_lines();

        key_bus.valid <= 1'b0;
        while (screen_q.size() != 0)
            @(posedge clk);
        repeat (LINE_LEN + 8) @(posedge clk);

        if (faults == 0 && screen_q.size() == 0)
            $display("[scancode_line_editor_top] OK");
        else
            $display("[scancode_line_editor_top] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/sle_pkg.sv
design/sle_if.sv
design/sle_ram.sv
design/sle_datapath.sv
design/sle_ctrl.sv
design/scancode_line_editor_top.sv
bench/scancode_line_editor_top_tb.sv
